/* design/ppi_pkg.sv */
// Package for the particle pool integrator.
// Holds the slot record, the per-slot update result, the sequencer states and constants.
// No dependencies.
`timescale 1ns / 1ps

package ppi_pkg;

  localparam int DEN_W = 24;
  localparam int SIZE_QW = 20;
  localparam int SIZE_NW = 44;
  localparam int COL_QW = 8;
  localparam int COL_NW = 32;

  localparam logic signed [25:0] ONE_Q16 = 26'sd65536;

  localparam logic CFG_START_RGBA = 1'b0;
  localparam logic CFG_END_RGBA = 1'b1;

  localparam logic FUNC_SPAWN = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] rot;
    logic signed [31:0] spin;
    logic signed [31:0] grav;
    logic [19:0] size_b;
    logic [19:0] size_f;
    logic [23:0] drag;
    logic [23:0] life;
    logic [23:0] life_cap;
  } rec_t;

  typedef struct packed {
    rec_t rec;
    logic [SIZE_NW-1:0] num_size;
    logic neg_size;
    logic [19:0] fin_size;
    logic [3:0][COL_NW-1:0] num_col;
    logic [3:0] neg_col;
    logic [3:0][7:0] fin_col;
    logic mx_zero;
    logic expired;
  } mot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_RDWAIT,
    ST_MOTION,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

/* design/ppi_mem.sv */
// Slot record memory with one write port and one registered read port.
// Depends on ppi_pkg for the record type.
`timescale 1ns / 1ps

module ppi_mem #(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  ppi_pkg::rec_t    wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output ppi_pkg::rec_t    rdata
);

  ppi_pkg::rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/ppi_div.sv */
// Restoring divider that produces one quotient bit per cycle.
// The quotient is known to fit in QW bits. Depends on nothing.
`timescale 1ns / 1ps

module ppi_div #(
  parameter int NW = 44,
  parameter int QW = 20,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          rem_nz,
  output logic          done
);

  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem;
  logic [QW-1:0] low;
  logic [CW-1:0] cnt;
  logic          run;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem, low[QW-1]};
  assign diff = trial - {1'b0, den};
  assign ge = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      rem <= num[NW-1:QW];
      low <= num[QW-1:0];
      cnt <= CW'(QW);
      run <= 1'b1;
      done <= 1'b0;
    end else if (run) begin
      rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
      low <= {low[QW-2:0], ge};
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        run <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quo = low;
  assign rem_nz = |rem;

endmodule

/* design/ppi_motion.sv */
// Five-stage update of one slot record: gravity, friction, integration, aging.
// Also forms the interpolation numerators. Depends on ppi_pkg.
`timescale 1ns / 1ps

module ppi_motion (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  ppi_pkg::rec_t  rec,
  input  logic [15:0]    dt,
  input  logic [31:0]    start_rgba,
  input  logic [31:0]    end_rgba,
  output logic           out_valid,
  output ppi_pkg::mot_t  res
);

  logic v1, v2, v3, v4, v5;
  ppi_pkg::rec_t r1, r2;
  logic signed [48:0] pg, ps;
  logic [39:0] pd;
  logic [23:0] life1, life2, lifec;
  logic signed [31:0] vy1, rot2;
  logic signed [25:0] fac;
  logic signed [20:0] dsz;
  logic [3:0][8:0] dcol;
  logic [3:0][7:0] fcol;
  logic signed [57:0] pvx, pvy;
  logic [ppi_pkg::SIZE_NW-1:0] numsz;
  logic [3:0][ppi_pkg::COL_NW-1:0] numcol;
  logic signed [31:0] vx2, vy2;
  logic signed [48:0] qx, qy;
  logic signed [31:0] px, py;
  logic [19:0] asz;
  logic [3:0][7:0] acol;
  logic signed [16:0] dts;

  assign dts = $signed({1'b0, dt});

  always_comb begin
    asz = dsz[20] ? 20'(-dsz) : dsz[19:0];
    for (int c = 0; c < 4; c++) begin
      acol[c] = dcol[c][8] ? 8'(-$signed(dcol[c])) : dcol[c][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      r1 <= rec;
      pg <= $signed(rec.grav) * dts;
      ps <= $signed(rec.spin) * dts;
      pd <= rec.drag * dt;
      life1 <= (rec.life > {8'b0, dt}) ? rec.life - {8'b0, dt} : '0;
    end
    if (v1) begin
      r2 <= r1;
      vy1 <= r1.vel_y - pg[47:16];
      fac <= ppi_pkg::ONE_Q16 - $signed({2'b0, pd[39:16]});
      rot2 <= r1.rot + ps[47:16];
      life2 <= life1;
      lifec <= (life1 > r1.life_cap) ? r1.life_cap : life1;
      dsz <= $signed({1'b0, r1.size_b}) - $signed({1'b0, r1.size_f});
      for (int c = 0; c < 4; c++) begin
        dcol[c] <= $signed({1'b0, start_rgba[31-8*c -: 8]})
                   - $signed({1'b0, end_rgba[31-8*c -: 8]});
        fcol[c] <= end_rgba[31-8*c -: 8];
      end
    end
    if (v2) begin
      pvx <= $signed(r2.vel_x) * fac;
      pvy <= vy1 * fac;
      numsz <= asz * lifec;
      for (int c = 0; c < 4; c++) begin
        numcol[c] <= acol[c] * lifec;
      end
    end
    if (v3) begin
      vx2 <= pvx[47:16];
      vy2 <= pvy[47:16];
      qx <= $signed(pvx[47:16]) * dts;
      qy <= $signed(pvy[47:16]) * dts;
    end
    if (v4) begin
      px <= r2.pos_x + qx[47:16];
      py <= r2.pos_y + qy[47:16];
    end
  end

  always_comb begin
    res.rec = r2;
    res.rec.pos_x = px;
    res.rec.pos_y = py;
    res.rec.vel_x = vx2;
    res.rec.vel_y = vy2;
    res.rec.rot = rot2;
    res.rec.life = life2;
    res.num_size = numsz;
    res.neg_size = dsz[20];
    res.fin_size = r2.size_f;
    res.num_col = numcol;
    for (int c = 0; c < 4; c++) begin
      res.neg_col[c] = dcol[c][8];
    end
    res.fin_col = fcol;
    res.mx_zero = (r2.life_cap == '0);
    res.expired = (life2 == '0);
  end

  assign out_valid = v5;

endmodule

/* design/particle_pool_integrator_core.sv */
// Top level of the particle pool integrator: sequencer, live bitmap and config registers.
// Depends on ppi_pkg, ppi_mem, ppi_motion and ppi_div.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low. A spawn item is written
// into the lowest free slot in the cycle it is taken and leaves busy low; it is
// dropped when the pool is full or its lifetime is zero. A tick item raises busy
// until every live slot has been reported. A tick first reads the life of each
// live slot to count the deaths, one memory read per cycle, so live_count is
// known before the first result. Then each live slot, in ascending order, is
// picked, read from memory, passed through the update pipeline and the size
// divider, and then reported with result_strobe high; the next slot is not
// picked until the last one is reported, since all slots share the single
// record memory and the bit-serial size divider. Each result is held for
// exactly one cycle and the receiver cannot stall it. The configuration channel
// is always ready. Reset marks every slot dead, clears the live total and
// restores the color registers; no clearing pass over the memory is needed.
module particle_pool_integrator_core #(
  parameter int POOL_SLOTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               func,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic [23:0]        lifetime,
  input  logic [19:0]        size_begin,
  input  logic [19:0]        size_final,
  input  logic signed [31:0] fall_accel,
  input  logic [23:0]        drag,
  input  logic signed [31:0] spin_rate,
  input  logic [15:0]        frame_dt,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               result_strobe,
  output logic [5:0]         slot,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] angle,
  output logic [19:0]        cur_size,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic [7:0]         alpha,
  output logic               expired,
  output logic               last,
  output logic [6:0]         live_count
);

  localparam int AW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;

  ppi_pkg::state_t state, state_next;

  logic [POOL_SLOTS-1:0] alive, scan_mask, work_mask;
  logic [6:0] live_total, deaths, live_after;
  logic [31:0] start_rgba, end_rgba;
  logic [15:0] dt;
  logic chk;
  logic [AW-1:0] cur;
  logic last_flag;

  logic [AW-1:0] free_idx, scan_idx, work_idx;
  logic pool_full;
  logic acc, spawn_ok;

  logic mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  ppi_pkg::rec_t mem_wdata, mem_rdata, spawn_rec;

  logic mot_in, mot_valid;
  ppi_pkg::mot_t mot;

  logic [ppi_pkg::SIZE_QW-1:0] q_size;
  logic nz_size, done_size;
  logic [3:0][ppi_pkg::COL_QW-1:0] q_col;
  logic [3:0] nz_col, done_col;
  logic div_done;
  logic [20:0] size_val;
  logic [3:0][8:0] col_val;

  always_comb begin
    free_idx = '0;
    pool_full = 1'b1;
    scan_idx = '0;
    work_idx = '0;
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      if (!alive[i]) begin
        free_idx = AW'(i);
        pool_full = 1'b0;
      end
      if (scan_mask[i]) begin
        scan_idx = AW'(i);
      end
      if (work_mask[i]) begin
        work_idx = AW'(i);
      end
    end
  end

  assign acc = start && !busy;
  assign spawn_ok = acc && (func == ppi_pkg::FUNC_SPAWN) && !pool_full && (lifetime != '0);

  always_comb begin
    spawn_rec.pos_x = pos_x;
    spawn_rec.pos_y = pos_y;
    spawn_rec.vel_x = vel_x;
    spawn_rec.vel_y = vel_y;
    spawn_rec.rot = '0;
    spawn_rec.spin = spin_rate;
    spawn_rec.grav = fall_accel;
    spawn_rec.size_b = size_begin;
    spawn_rec.size_f = size_final;
    spawn_rec.drag = drag;
    spawn_rec.life = lifetime;
    spawn_rec.life_cap = lifetime;
  end

  always_comb begin
    state_next = state;
    case (state)
      ppi_pkg::ST_IDLE: begin
        if (acc && (func == ppi_pkg::FUNC_TICK)) begin
          state_next = ppi_pkg::ST_SCAN;
        end
      end
      ppi_pkg::ST_SCAN: begin
        if ((scan_mask == '0) && !chk) begin
          state_next = ppi_pkg::ST_PICK;
        end
      end
      ppi_pkg::ST_PICK: begin
        state_next = (work_mask == '0) ? ppi_pkg::ST_IDLE : ppi_pkg::ST_RDWAIT;
      end
      ppi_pkg::ST_RDWAIT: begin
        state_next = ppi_pkg::ST_MOTION;
      end
      ppi_pkg::ST_MOTION: begin
        if (mot_valid) begin
          state_next = ppi_pkg::ST_DIV;
        end
      end
      ppi_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = ppi_pkg::ST_EMIT;
        end
      end
      ppi_pkg::ST_EMIT: begin
        state_next = ppi_pkg::ST_PICK;
      end
      default: begin
        state_next = ppi_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy = (state != ppi_pkg::ST_IDLE);
    result_strobe = (state == ppi_pkg::ST_EMIT);
    mot_in = (state == ppi_pkg::ST_RDWAIT);
    mem_re = ((state == ppi_pkg::ST_SCAN) && (scan_mask != '0))
             || ((state == ppi_pkg::ST_PICK) && (work_mask != '0));
    mem_raddr = (state == ppi_pkg::ST_SCAN) ? scan_idx : work_idx;
    mem_we = spawn_ok || (state == ppi_pkg::ST_EMIT);
    mem_waddr = spawn_ok ? free_idx : cur;
    mem_wdata = spawn_ok ? spawn_rec : mot.rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppi_pkg::ST_IDLE;
      alive <= '0;
      live_total <= '0;
      scan_mask <= '0;
      work_mask <= '0;
      chk <= 1'b0;
      deaths <= '0;
      start_rgba <= 32'hFFFF_FFFF;
      end_rgba <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        case (cfg_index)
          ppi_pkg::CFG_START_RGBA: start_rgba <= cfg_data;
          ppi_pkg::CFG_END_RGBA: end_rgba <= cfg_data;
          default: end_rgba <= end_rgba;
        endcase
      end
      if (spawn_ok) begin
        alive[free_idx] <= 1'b1;
        live_total <= live_total + 1'b1;
      end
      case (state)
        ppi_pkg::ST_IDLE: begin
          if (acc && (func == ppi_pkg::FUNC_TICK)) begin
            dt <= frame_dt;
            scan_mask <= alive;
            work_mask <= alive;
            deaths <= '0;
            chk <= 1'b0;
          end
        end
        ppi_pkg::ST_SCAN: begin
          chk <= (scan_mask != '0);
          if (scan_mask != '0) begin
            scan_mask[scan_idx] <= 1'b0;
          end
          if (chk && (mem_rdata.life <= {8'b0, dt})) begin
            deaths <= deaths + 1'b1;
          end
          if ((scan_mask == '0) && !chk) begin
            live_after <= live_total - deaths;
          end
        end
        ppi_pkg::ST_PICK: begin
          if (work_mask != '0) begin
            cur <= work_idx;
            work_mask[work_idx] <= 1'b0;
            last_flag <= ((work_mask & ~(POOL_SLOTS'(1) << work_idx)) == '0);
          end
        end
        ppi_pkg::ST_EMIT: begin
          if (mot.expired) begin
            alive[cur] <= 1'b0;
            live_total <= live_total - 1'b1;
          end
        end
        default: begin
          chk <= 1'b0;
        end
      endcase
    end
  end

  ppi_mem #(
    .DEPTH(POOL_SLOTS),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  ppi_motion u_motion (
    .clk(clk),
    .rst(rst),
    .in_valid(mot_in),
    .rec(mem_rdata),
    .dt(dt),
    .start_rgba(start_rgba),
    .end_rgba(end_rgba),
    .out_valid(mot_valid),
    .res(mot)
  );

  ppi_div #(
    .NW(ppi_pkg::SIZE_NW),
    .QW(ppi_pkg::SIZE_QW),
    .DW(ppi_pkg::DEN_W)
  ) u_div_size (
    .clk(clk),
    .rst(rst),
    .start(mot_valid),
    .num(mot.num_size),
    .den(mot.rec.life_cap),
    .quo(q_size),
    .rem_nz(nz_size),
    .done(done_size)
  );

  for (genvar c = 0; c < 4; c++) begin : g_col
    ppi_div #(
      .NW(ppi_pkg::COL_NW),
      .QW(ppi_pkg::COL_QW),
      .DW(ppi_pkg::DEN_W)
    ) u_div_col (
      .clk(clk),
      .rst(rst),
      .start(mot_valid),
      .num(mot.num_col[c]),
      .den(mot.rec.life_cap),
      .quo(q_col[c]),
      .rem_nz(nz_col[c]),
      .done(done_col[c])
    );
  end

  assign div_done = done_size && (&done_col);

  always_comb begin
    if (mot.mx_zero) begin
      size_val = {1'b0, mot.fin_size};
    end else if (mot.neg_size) begin
      size_val = {1'b0, mot.fin_size} - {1'b0, q_size} - {20'b0, nz_size};
    end else begin
      size_val = {1'b0, mot.fin_size} + {1'b0, q_size};
    end
    for (int c = 0; c < 4; c++) begin
      if (mot.mx_zero) begin
        col_val[c] = {1'b0, mot.fin_col[c]};
      end else if (mot.neg_col[c]) begin
        col_val[c] = {1'b0, mot.fin_col[c]} - {1'b0, q_col[c]} - {8'b0, nz_col[c]};
      end else begin
        col_val[c] = {1'b0, mot.fin_col[c]} + {1'b0, q_col[c]};
      end
    end
  end

  assign cfg_ready = 1'b1;
  assign slot = 6'(cur);
  assign out_x = mot.rec.pos_x;
  assign out_y = mot.rec.pos_y;
  assign angle = mot.rec.rot;
  assign cur_size = size_val[19:0];
  assign red = col_val[0][7:0];
  assign green = col_val[1][7:0];
  assign blue = col_val[2][7:0];
  assign alpha = col_val[3][7:0];
  assign expired = mot.expired;
  assign last = last_flag;
  assign live_count = live_after;

endmodule
